@@ rtl/hnns_pkg.sv @@
package hnns_pkg;

  // Default upper bound on the name length; a name must stay below it.
  localparam int NAME_LIMIT_DEF = 64;

  localparam int KIND_W    = 1;
  localparam int CHAR_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int FIELD_W   = 6;
  localparam int NUMBER_W  = 32;
  // Room for one multiply-by-ten and digit add above the 32-bit value.
  localparam int PRODUCT_W = NUMBER_W + 4;

  localparam logic [KIND_W-1:0] KIND_CHAR = 1'b0;
  localparam logic [KIND_W-1:0] KIND_END  = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z   = 8'h5A;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_TOOLONG    = 3'd2,
    ST_BADCHAR    = 3'd3,
    ST_UNNUMBERED = 3'd4,
    ST_ALLDIGITS  = 3'd5,
    ST_RANGE      = 3'd6
  } status_e;

  // Condensed view of the scan state, handed to the result stage.
  typedef struct packed {
    logic                is_empty;
    logic                too_long;
    logic                bad_char;
    logic                unnumbered;
    logic                all_digits;
    logic                overflow;
    logic [FIELD_W-1:0]  stem_length;
    logic [NUMBER_W-1:0] number;
    logic [FIELD_W-1:0]  digit_count;
  } summary_t;

endpackage

@@ rtl/hnns_scan.sv @@
module hnns_scan
  import hnns_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [CHAR_W-1:0] char_code_i,
  output summary_t          summary_o
);

  localparam int CNT_W = $clog2(NAME_LIMIT + 1);
  localparam int EXT_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(NAME_LIMIT);

  logic [CNT_W-1:0]    char_count_q, char_count_d;
  logic [CNT_W-1:0]    run_digits_q, run_digits_d;
  logic [NUMBER_W-1:0] run_value_q, run_value_d;
  logic                first_hyph_q, first_hyph_d;
  logic                last_hyph_q, last_hyph_d;
  logic                bad_q, bad_d;
  logic                ovf_q, ovf_d;

  logic                digit_hit, is_hyph, is_host;
  logic [PRODUCT_W-1:0] product;
  logic [CNT_W-1:0]    stem_diff;
  logic [EXT_W-1:0]    stem_ext, digits_ext;

  assign digit_hit = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign is_hyph   = (char_code_i == CHAR_HYPHEN);
  assign is_host   = digit_hit || is_hyph
                  || ((char_code_i >= CHAR_LC_A) && (char_code_i <= CHAR_LC_Z))
                  || ((char_code_i >= CHAR_UC_A) && (char_code_i <= CHAR_UC_Z));

  // run * 10 + digit as (run << 3) + (run << 1) + digit.
  assign product = ({{(PRODUCT_W-NUMBER_W){1'b0}}, run_value_q} << 3)
                 + ({{(PRODUCT_W-NUMBER_W){1'b0}}, run_value_q} << 1)
                 + PRODUCT_W'(char_code_i - CHAR_ZERO);

  always_comb begin
    char_count_d = char_count_q;
    run_digits_d = run_digits_q;
    run_value_d  = run_value_q;
    first_hyph_d = first_hyph_q;
    last_hyph_d  = last_hyph_q;
    bad_d        = bad_q;
    ovf_d        = ovf_q;
    if (take_i) begin
      if (kind_i == KIND_END) begin
        char_count_d = '0;
        run_digits_d = '0;
        run_value_d  = '0;
        first_hyph_d = 1'b0;
        last_hyph_d  = 1'b0;
        bad_d        = 1'b0;
        ovf_d        = 1'b0;
      end else begin
        if (char_count_q == '0) begin
          first_hyph_d = is_hyph;
        end
        last_hyph_d = is_hyph;
        if (!is_host) begin
          bad_d = 1'b1;
        end
        if (digit_hit) begin
          if (!ovf_q) begin
            if (|product[PRODUCT_W-1:NUMBER_W]) begin
              ovf_d = 1'b1;
            end else begin
              run_value_d = product[NUMBER_W-1:0];
            end
          end
          if (run_digits_q < LIMIT) begin
            run_digits_d = run_digits_q + CNT_W'(1);
          end
        end else begin
          run_value_d  = '0;
          run_digits_d = '0;
          ovf_d        = 1'b0;
        end
        if (char_count_q < LIMIT) begin
          char_count_d = char_count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      run_digits_q <= '0;
      run_value_q  <= '0;
      first_hyph_q <= 1'b0;
      last_hyph_q  <= 1'b0;
      bad_q        <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      char_count_q <= char_count_d;
      run_digits_q <= run_digits_d;
      run_value_q  <= run_value_d;
      first_hyph_q <= first_hyph_d;
      last_hyph_q  <= last_hyph_d;
      bad_q        <= bad_d;
      ovf_q        <= ovf_d;
    end
  end

  assign stem_diff  = char_count_q - run_digits_q;
  assign stem_ext   = EXT_W'(stem_diff);
  assign digits_ext = EXT_W'(run_digits_q);

  assign summary_o.is_empty    = (char_count_q == '0);
  assign summary_o.too_long    = (char_count_q >= LIMIT);
  assign summary_o.bad_char    = bad_q || first_hyph_q || last_hyph_q;
  assign summary_o.unnumbered  = (run_digits_q == '0);
  assign summary_o.all_digits  = (run_digits_q >= char_count_q);
  assign summary_o.overflow    = ovf_q;
  assign summary_o.stem_length = stem_ext[FIELD_W-1:0];
  assign summary_o.number      = run_value_q;
  assign summary_o.digit_count = digits_ext[FIELD_W-1:0];

endmodule

@@ rtl/hnns_report.sv @@
module hnns_report
  import hnns_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                emit_i,
  input  summary_t            summary_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [FIELD_W-1:0]  stem_length_o,
  output logic [NUMBER_W-1:0] number_o,
  output logic [FIELD_W-1:0]  digit_count_o
);

  status_e             status;
  logic                valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [FIELD_W-1:0]  stem_q, digits_q;
  logic [NUMBER_W-1:0] number_q;

  // First matching error wins.
  always_comb begin
    if (summary_i.is_empty) begin
      status = ST_EMPTY;
    end else if (summary_i.too_long) begin
      status = ST_TOOLONG;
    end else if (summary_i.bad_char) begin
      status = ST_BADCHAR;
    end else if (summary_i.unnumbered) begin
      status = ST_UNNUMBERED;
    end else if (summary_i.all_digits) begin
      status = ST_ALLDIGITS;
    end else if (summary_i.overflow) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      status_q <= status;
      if (status == ST_OK) begin
        stem_q   <= summary_i.stem_length;
        number_q <= summary_i.number;
        digits_q <= summary_i.digit_count;
      end else begin
        stem_q   <= '0;
        number_q <= '0;
        digits_q <= '0;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = status_q;
  assign stem_length_o = stem_q;
  assign number_o      = number_q;
  assign digit_count_o = digits_q;

endmodule

@@ rtl/host_name_number_split.sv @@
// An end beat passes the input register, then the result register. Throughput:
// one beat per cycle while the input is not stalled; the scan state for a
// character is updated in the cycle after its input register, with no iteration.
// Reset: rst_ni clears the scan state and both valid flags asynchronously.
// The block may take the next beat while a finished result is still waiting.
module host_name_number_split
  import hnns_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [FIELD_W-1:0]  stem_length_o,
  output logic [NUMBER_W-1:0] number_o,
  output logic [FIELD_W-1:0]  digit_count_o
);

  // Input register: holds one beat in front of the scan logic.
  logic              item_valid_q;
  logic [KIND_W-1:0] item_kind_q;
  logic [CHAR_W-1:0] item_char_q;

  logic     item_hold;
  logic     take;
  logic     emit;
  summary_t summary;

  // An end beat can only move on when the result register is free or
  // being emptied in this cycle. Character beats never wait.
  assign item_hold  = (item_kind_q == KIND_END) && out_valid_o && out_stall_i;
  assign in_stall_o = item_valid_q && item_hold;
  assign take       = item_valid_q && !item_hold;
  assign emit       = take && (item_kind_q == KIND_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_kind_q <= kind_i;
      item_char_q <= char_code_i;
    end
  end

  // Character checks, trailing digit run and counters. The summary is taken
  // from the state as it stands before an end beat clears it.
  hnns_scan #(
    .NAME_LIMIT(NAME_LIMIT)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .kind_i     (item_kind_q),
    .char_code_i(item_char_q),
    .summary_o  (summary)
  );

  // Status priority and the result register.
  hnns_report u_report (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .summary_i    (summary),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .stem_length_o(stem_length_o),
    .number_o     (number_o),
    .digit_count_o(digit_count_o)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import hnns_pkg::*;

  // Run shape. The watchdog limit sits far above the receiver hold-off,
  // which is the longest stretch in which no beat moves on either channel.
  localparam int RANDOM_BEATS   = 650;
  localparam int HOLD_CYCLES    = 600;
  localparam int HOLD_AT_RESULT = 40;
  localparam int IDLE_LIMIT     = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PLAN_ROWS      = 20;
  localparam int NO_RAW         = -1;

  // One split result, laid out as the output ports present it.
  typedef struct packed {
    status_e             status;
    logic [FIELD_W-1:0]  stem_length;
    logic [NUMBER_W-1:0] number;
    logic [FIELD_W-1:0]  digit_count;
  } split_t;

  // A directed name is head, then body repeated reps times, then tail, then
  // an optional raw byte that a string literal cannot carry. Where typed is
  // set, the expected split is taken from the row rather than the predictor.
  typedef struct {
    string  head;
    string  body;
    int     reps;
    string  tail;
    int     raw;
    bit     typed;
    split_t want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i        = KIND_CHAR;
  logic [CHAR_W-1:0]   char_code_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [FIELD_W-1:0]  stem_length_o;
  logic [NUMBER_W-1:0] number_o;
  logic [FIELD_W-1:0]  digit_count_o;

  // Predictor state: a copy of the scan that the block keeps for one name.
  logic [7:0]          scan_count;
  logic                scan_first_hyphen;
  logic                scan_last_hyphen;
  logic                scan_bad;
  logic [NUMBER_W-1:0] run_value;
  logic [7:0]          run_width;
  logic                run_too_big;

  split_t     expected_splits[$];
  logic [7:0] name_chars[$];
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  bit         quiet_name   = 1'b0;
  bit         hold_on      = 1'b0;

  // The directed names: boundaries of the legal set, every error code, the 32-bit
  // limit of the number and the 63-character limit of the name, saturation of the
  // count, and runs that restart.
  plan_row_t plan [PLAN_ROWS] = '{
    '{"",      "",   0,  "",           NO_RAW, 1'b1, '{ST_EMPTY, 6'd0, 32'd0, 6'd0}},
    '{"a",     "",   0,  "1",          NO_RAW, 1'b1, '{ST_OK, 6'd1, 32'd1, 6'd1}},
    '{"-a",    "",   0,  "1",          NO_RAW, 1'b1, '{ST_BADCHAR, 6'd0, 32'd0, 6'd0}},
    '{"a1",    "",   0,  "-",          NO_RAW, 1'b1, '{ST_BADCHAR, 6'd0, 32'd0, 6'd0}},
    '{"ab",    "",   0,  "",           8'h00,  1'b1, '{ST_BADCHAR, 6'd0, 32'd0, 6'd0}},
    '{"ab1",   "",   0,  "",           8'hFF,  1'b1, '{ST_BADCHAR, 6'd0, 32'd0, 6'd0}},
    '{"host",  "",   0,  "",           NO_RAW, 1'b1, '{ST_UNNUMBERED, 6'd0, 32'd0, 6'd0}},
    '{"123",   "",   0,  "",           NO_RAW, 1'b1, '{ST_ALLDIGITS, 6'd0, 32'd0, 6'd0}},
    '{"a",     "",   0,  "4294967296", NO_RAW, 1'b1, '{ST_RANGE, 6'd0, 32'd0, 6'd0}},
    '{"a",     "",   0,  "4294967295", NO_RAW, 1'b1,
      '{ST_OK, 6'd1, 32'hFFFF_FFFF, 6'd10}},
    '{"",      "x",  53, "4294967295", NO_RAW, 1'b1,
      '{ST_OK, 6'd53, 32'hFFFF_FFFF, 6'd10}},
    '{"",      "ab", 32, "",           NO_RAW, 1'b1, '{ST_TOOLONG, 6'd0, 32'd0, 6'd0}},
    '{"",      "-",  70, "",           NO_RAW, 1'b1, '{ST_TOOLONG, 6'd0, 32'd0, 6'd0}},
    '{"az",    "",   0,  "AZ@[{/:1",   8'h60,  1'b1, '{ST_BADCHAR, 6'd0, 32'd0, 6'd0}},
    '{"Zz-Aa", "",   0,  "007",        NO_RAW, 1'b0, '{ST_OK, 6'd0, 32'd0, 6'd0}},
    '{"a",     "0",  62, "",           NO_RAW, 1'b0, '{ST_OK, 6'd0, 32'd0, 6'd0}},
    '{"",      "a",  62, "9",          NO_RAW, 1'b0, '{ST_OK, 6'd0, 32'd0, 6'd0}},
    '{"9a",    "0",  15, "42",         NO_RAW, 1'b0, '{ST_OK, 6'd0, 32'd0, 6'd0}},
    '{"a",     "9",  11, "x1",         NO_RAW, 1'b0, '{ST_OK, 6'd0, 32'd0, 6'd0}},
    '{"b",     "",   0,  "5000000000", NO_RAW, 1'b0, '{ST_OK, 6'd0, 32'd0, 6'd0}}
  };

  host_name_number_split u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .stem_length_o (stem_length_o),
    .number_o      (number_o),
    .digit_count_o (digit_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_scan();
    scan_count        = '0;
    scan_first_hyphen = 1'b0;
    scan_last_hyphen  = 1'b0;
    scan_bad          = 1'b0;
    run_value         = '0;
    run_width         = '0;
    run_too_big       = 1'b0;
  endfunction

  // Advances the predictor by one input beat. A character beat only updates
  // the scan; an end beat yields the split and returns the scan to empty.
  function automatic bit step_splitter(input logic [KIND_W-1:0] kind,
                                       input logic [CHAR_W-1:0] code,
                                       output split_t res);
    logic        digit;
    logic        hyphen;
    logic        letter;
    logic [63:0] grown;
    res.status      = ST_OK;
    res.stem_length = '0;
    res.number      = '0;
    res.digit_count = '0;
    if (kind == KIND_CHAR) begin
      digit  = code >= CHAR_ZERO && code <= CHAR_NINE;
      hyphen = code == CHAR_HYPHEN;
      letter = (code >= CHAR_LC_A && code <= CHAR_LC_Z) ||
               (code >= CHAR_UC_A && code <= CHAR_UC_Z);
      if (scan_count == 0) scan_first_hyphen = hyphen;
      scan_last_hyphen = hyphen;
      if (!(letter || digit || hyphen)) scan_bad = 1'b1;
      if (digit) begin
        // Once the run has overflowed, its value freezes at the last fit.
        if (!run_too_big) begin
          grown = 64'(run_value) * 10 + 64'(code - CHAR_ZERO);
          if (grown > 64'hFFFF_FFFF) run_too_big = 1'b1;
          else run_value = grown[NUMBER_W-1:0];
        end
        if (run_width < NAME_LIMIT_DEF) run_width++;
      end else begin
        run_value   = '0;
        run_width   = '0;
        run_too_big = 1'b0;
      end
      if (scan_count < NAME_LIMIT_DEF) scan_count++;
      return 1'b0;
    end
    if (scan_count == 0) res.status = ST_EMPTY;
    else if (scan_count >= NAME_LIMIT_DEF) res.status = ST_TOOLONG;
    else if (scan_bad || scan_first_hyphen || scan_last_hyphen) res.status = ST_BADCHAR;
    else if (run_width == 0) res.status = ST_UNNUMBERED;
    else if (run_width >= scan_count) res.status = ST_ALLDIGITS;
    else if (run_too_big) res.status = ST_RANGE;
    if (res.status == ST_OK) begin
      res.stem_length = FIELD_W'(scan_count - run_width);
      res.number      = run_value;
      res.digit_count = FIELD_W'(run_width);
    end
    clear_scan();
    return 1'b1;
  endfunction

  function automatic logic [7:0] any_letter();
    return $urandom_range(0, 1) ? CHAR_LC_A + 8'($urandom_range(0, 25))
                                : CHAR_UC_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void push_text(input string text);
    for (int k = 0; k < text.len(); k++) name_chars.push_back(text[k]);
  endfunction

  // A stem never opens with a hyphen; past one character it closes on a
  // non-digit, so the digit run which follows it starts exactly where we think.
  function automatic void add_stem(input int len);
    int pick;
    for (int j = 0; j < len; j++) begin
      pick = $urandom_range(0, 5);
      if (j == 0) name_chars.push_back(pick < 4 ? any_letter() : any_digit());
      else if (j == len - 1) name_chars.push_back(pick < 4 ? any_letter() : CHAR_HYPHEN);
      else if (pick < 3) name_chars.push_back(any_letter());
      else if (pick < 5) name_chars.push_back(any_digit());
      else name_chars.push_back(CHAR_HYPHEN);
    end
  endfunction

  // Trailing digit runs: short ones, ten digits right at the 32-bit limit,
  // runs padded with leading zeros, and runs long enough to overflow.
  function automatic void add_run();
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 5)) name_chars.push_back(any_digit());
      1: begin
        push_text("429496729");
        name_chars.push_back(any_digit());
      end
      2: begin
        repeat ($urandom_range(1, 6)) name_chars.push_back(CHAR_ZERO);
        repeat ($urandom_range(1, 4)) name_chars.push_back(any_digit());
      end
      default: repeat ($urandom_range(10, 13)) name_chars.push_back(any_digit());
    endcase
  endfunction

  // Most random names are well formed, so that the number parser is worked
  // hard; the rest are broken in each of the ways the block recognises.
  function automatic void compose_random_name();
    int mode;
    name_chars.delete();
    mode = $urandom_range(0, 99);
    if (mode < 72) begin
      add_stem($urandom_range(1, 12));
      add_run();
    end else if (mode < 76) begin
      // An end beat with no characters before it.
    end else if (mode < 84) begin
      repeat ($urandom_range(1, 12)) name_chars.push_back(8'($urandom));
    end else if (mode < 90) begin
      add_stem($urandom_range(1, 8));
      add_run();
      name_chars[$urandom_range(0, name_chars.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (mode < 92) begin
      add_stem($urandom_range(1, 6));
      add_run();
      name_chars.push_front(CHAR_HYPHEN);
    end else if (mode < 94) begin
      add_stem($urandom_range(1, 6));
      add_run();
      name_chars.push_back(CHAR_HYPHEN);
    end else if (mode < 96) begin
      add_run();
    end else if (mode < 98) begin
      add_stem($urandom_range(1, 10));
    end else begin
      // Lengths either side of the limit on the name.
      add_stem($urandom_range(58, 75));
      add_run();
    end
  endfunction

  // Offers every character of name_chars and then the end beat, each after
  // a random gap, and files the split that the end beat is due to produce.
  task automatic offer_name(input bit typed, input split_t want);
    split_t predicted;
    int     gap;
    for (int i = 0; i <= name_chars.size(); i++) begin
      gap = (quiet_name || hold_on) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      kind_i      <= (i == name_chars.size()) ? KIND_END : KIND_CHAR;
      char_code_i <= (i == name_chars.size()) ? 8'($urandom) : name_chars[i];
      do @(posedge clk_i); while (in_stall_o);
      if (step_splitter(kind_i, char_code_i, predicted))
        expected_splits.push_back(typed ? want : predicted);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Sender side: reset, the directed names, then random names until enough
  // beats have gone in, then the drain and the verdict.
  initial begin : name_source
    int beats;
    clear_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[r]) begin
      name_chars.delete();
      push_text(plan[r].head);
      repeat (plan[r].reps) push_text(plan[r].body);
      push_text(plan[r].tail);
      if (plan[r].raw != NO_RAW) name_chars.push_back(8'(plan[r].raw));
      quiet_name = $urandom_range(0, 3) == 0;
      offer_name(plan[r].typed, plan[r].want);
    end
    beats = 0;
    while (beats < RANDOM_BEATS) begin
      compose_random_name();
      quiet_name = $urandom_range(0, 3) == 0;
      offer_name(1'b0, '0);
      beats += name_chars.size() + 1;
    end
    in_valid_i <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk_i);
    // Keep running for DRAIN_CYCLES, so that a stray result beat would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_splits.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver side: a random stall before each result beat, with calm spells
  // of no stall at all, and once a long hold-off while the sender streams
  // flat out, so that the block backs up and has to stall its input.
  initial begin : result_sink
    int taken;
    int pause;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == HOLD_AT_RESULT) begin
        hold_on = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on = 1'b0;
      end else begin
        if (taken % 16 == 0) calm = $urandom_range(0, 2) == 0;
        pause = calm ? 0 : $urandom_range(0, 14);
        if (pause > 0) begin
          out_stall_i <= 1'b1;
          repeat (pause) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
    end
  end

  // Every result beat is held against the oldest split still outstanding.
  always @(posedge clk_i) begin : split_check
    split_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_splits.size() == 0) begin
        report_mismatch("unexpected result beat, status", 32'(status_o), '0);
      end else begin
        want = expected_splits.pop_front();
        if (status_o != want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (stem_length_o != want.stem_length)
          report_mismatch("stem length", 32'(stem_length_o), 32'(want.stem_length));
        if (number_o != want.number)
          report_mismatch("number", number_o, want.number);
        if (digit_count_o != want.digit_count)
          report_mismatch("digit count", 32'(digit_count_o), 32'(want.digit_count));
      end
    end
  end

  // Ends the run if no beat moves on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
